@@ hdl/iisq_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and widths for the integral and squared integral image block.
package iisq_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int PIXEL_W = 8;
   localparam int CFG_W   = 11;
   localparam int SUM_W   = 28;
   localparam int SQ_W    = 36;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   localparam int ROW_SUM_W = PIXEL_W + COL_W;
   localparam int ROW_SQ_W  = 2 * PIXEL_W + COL_W;

   localparam int WCMP_W = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
   localparam int HCMP_W = (CFG_W > ROW_W + 1) ? CFG_W : ROW_W + 1;

   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = CSR_INDEX_W'(1);

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = CFG_W'(1024);
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = CFG_W'(1024);

endpackage

@@ hdl/iisq_channels.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixel words in and sum words out.
interface iisq_req_if import iisq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface iisq_rsp_if import iisq_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SUM_W-1:0] area_sum;
   logic [SQ_W-1:0]  square_area_sum;
   logic             frame_last;

   modport source (output valid, output area_sum, output square_area_sum,
                   output frame_last, input ready);
   modport sink   (input valid, input area_sum, input square_area_sum,
                   input frame_last, output ready);
endinterface

@@ hdl/integral_and_square_integral_image_top.sv @@
`timescale 1ns / 1ps
// Integral and squared integral image, one pixel word per clock unless stalled.
//
// Pixel words enter on req_chan in raster order; one sum word leaves on rsp_chan
// for each, carrying the summed area, the summed squared area and a flag on the
// frame's last pixel. Frame size comes from csr registers frame_width (index 0)
// and frame_height (index 1); zero acts as 1, sizes above the maximum act as the
// maximum, and a write to either register restarts the frame with the next pixel.
// Each sum word passes through the stage register, then the output register,
// before it shows on rsp_chan.
// One pixel per cycle unless rsp_chan stalls: a stage register holds the row
// sums and the line-store read, the output register holds the finished word.
// The line store is one read and one write per cycle, bypassed when width is 1.
// Reset sets both sizes to 1024 and empties the pipeline; the line store is not
// cleared, since the first row never reads it.
// When the receiver stalls, the output word holds, then the stage register fills,
// and req_chan.ready drops; nothing is lost or repeated.
module integral_and_square_integral_image_top import iisq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_write_data,
   iisq_req_if.sink               req_chan,
   iisq_rsp_if.source             rsp_chan
);

   logic [CFG_W-1:0]     width_ff, width_in;
   logic [CFG_W-1:0]     height_ff, height_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [ROW_SUM_W-1:0] rsum_ff, rsum_in;
   logic [ROW_SQ_W-1:0]  rsq_ff, rsq_in;

   logic                 s1_v_ff, s1_v_in;
   logic [ROW_SUM_W-1:0] s1_rsum_ff;
   logic [ROW_SQ_W-1:0]  s1_rsq_ff;
   logic [COL_W-1:0]     s1_col_ff;
   logic                 s1_top_ff;
   logic                 s1_last_ff;
   logic                 s1_fwd_ff;
   logic [SUM_W-1:0]     fwd_sum_ff;
   logic [SQ_W-1:0]      fwd_sq_ff;
   logic [SUM_W-1:0]     rd_sum_ff;
   logic [SQ_W-1:0]      rd_sq_ff;

   logic                 out_v_ff, out_v_in;
   logic [SUM_W-1:0]     out_sum_ff;
   logic [SQ_W-1:0]      out_sq_ff;
   logic                 out_last_ff;

   logic [SUM_W-1:0]     mem_sum [MAX_WIDTH];
   logic [SQ_W-1:0]      mem_sq  [MAX_WIDTH];

   logic [WCMP_W-1:0]    width_ext;
   logic [HCMP_W-1:0]    height_ext;
   logic [COL_W-1:0]     last_col;
   logic [ROW_W-1:0]     last_row;
   logic                 col_last, row_last;
   logic                 accept, s1_move, out_free, cfg_hit;
   logic [2*PIXEL_W-1:0] pix_sq;
   logic [ROW_SUM_W-1:0] rsum_next;
   logic [ROW_SQ_W-1:0]  rsq_next;
   logic [SUM_W-1:0]     above_sum, area;
   logic [SQ_W-1:0]      above_sq, area_sq;

   // frame size clamp
   always_comb begin
      width_ext  = WCMP_W'(width_ff);
      height_ext = HCMP_W'(height_ff);
      if (width_ff == '0) begin
         last_col = '0;
      end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
         last_col = COL_W'(MAX_WIDTH - 1);
      end else begin
         last_col = COL_W'(width_ext - WCMP_W'(1));
      end
      if (height_ff == '0) begin
         last_row = '0;
      end else if (height_ext > HCMP_W'(MAX_HEIGHT)) begin
         last_row = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         last_row = ROW_W'(height_ext - HCMP_W'(1));
      end
   end

   assign out_free = !out_v_ff || rsp_chan.ready;
   assign s1_move  = s1_v_ff && out_free;
   assign req_chan.ready = !s1_v_ff || s1_move;
   assign accept   = req_chan.valid && req_chan.ready;
   assign cfg_hit  = csr_write_enable &&
                     (csr_index == REG_FRAME_WIDTH || csr_index == REG_FRAME_HEIGHT);

   assign col_last  = (col_ff == last_col);
   assign row_last  = (row_ff >= last_row);
   assign pix_sq    = (2*PIXEL_W)'(req_chan.pixel) * (2*PIXEL_W)'(req_chan.pixel);
   assign rsum_next = rsum_ff + ROW_SUM_W'(req_chan.pixel);
   assign rsq_next  = rsq_ff + ROW_SQ_W'(pix_sq);

   // frame counters and row sums
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      rsum_in   = rsum_ff;
      rsq_in    = rsq_ff;
      if (accept) begin
         if (col_last) begin
            col_in  = '0;
            rsum_in = '0;
            rsq_in  = '0;
            row_in  = row_last ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in  = col_ff + COL_W'(1);
            rsum_in = rsum_next;
            rsq_in  = rsq_next;
         end
      end
      if (cfg_hit) begin
         if (csr_index == REG_FRAME_WIDTH) begin
            width_in = csr_write_data;
         end else begin
            height_in = csr_write_data;
         end
         col_in  = '0;
         row_in  = '0;
         rsum_in = '0;
         rsq_in  = '0;
      end
   end

   // add the row above, taking the word just finished when it is the same column
   always_comb begin
      above_sum = '0;
      above_sq  = '0;
      if (s1_top_ff) begin
         above_sum = s1_fwd_ff ? fwd_sum_ff : rd_sum_ff;
         above_sq  = s1_fwd_ff ? fwd_sq_ff  : rd_sq_ff;
      end
      area    = SUM_W'(s1_rsum_ff) + above_sum;
      area_sq = SQ_W'(s1_rsq_ff) + above_sq;
   end

   assign s1_v_in  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_v_ff);
   assign out_v_in = s1_move ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RESET;
         height_ff <= FRAME_HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         rsum_ff   <= '0;
         rsq_ff    <= '0;
         s1_v_ff   <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         rsum_ff   <= rsum_in;
         rsq_ff    <= rsq_in;
         s1_v_ff   <= s1_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rsum_ff <= rsum_next;
         s1_rsq_ff  <= rsq_next;
         s1_col_ff  <= col_ff;
         s1_top_ff  <= (row_ff != '0);
         s1_last_ff <= col_last && row_last;
         s1_fwd_ff  <= s1_v_ff && (s1_col_ff == col_ff);
         fwd_sum_ff <= area;
         fwd_sq_ff  <= area_sq;
      end
      if (s1_move) begin
         out_sum_ff  <= area;
         out_sq_ff   <= area_sq;
         out_last_ff <= s1_last_ff;
      end
   end

   // line store of the previous row's sums
   always_ff @(posedge clock) begin
      if (s1_move) begin
         mem_sum[s1_col_ff] <= area;
         mem_sq[s1_col_ff]  <= area_sq;
      end
      if (accept) begin
         rd_sum_ff <= mem_sum[col_ff];
         rd_sq_ff  <= mem_sq[col_ff];
      end
   end

   assign rsp_chan.valid           = out_v_ff;
   assign rsp_chan.area_sum        = out_sum_ff;
   assign rsp_chan.square_area_sum = out_sq_ff;
   assign rsp_chan.frame_last      = out_last_ff;

endmodule

@@ verif/integral_sum_checker.sv @@
`timescale 1ns / 1ps
// Checker that predicts and compares the summed-area and squared-sum words of the block.
module integral_sum_checker import iisq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_write_data,
   iisq_req_if                    req_watch,
   iisq_rsp_if                    rsp_watch,
   output int                     mismatch_count,
   output int                     pending_count,
   output int                     checked_count
);

   typedef struct packed {
      logic [SUM_W-1:0] area;
      logic [SQ_W-1:0]  square;
      logic             last;
   } sum_word_type;

   logic [CFG_W-1:0] frame_width;
   logic [CFG_W-1:0] frame_height;
   int unsigned      column;
   int unsigned      row;
   logic [SUM_W-1:0] row_sum;
   logic [SQ_W-1:0]  row_square_sum;
   logic [SUM_W-1:0] line_sum [MAX_WIDTH];
   logic [SQ_W-1:0]  line_square_sum [MAX_WIDTH];
   sum_word_type     expected_sums [$];
   sum_word_type     want;
   int               errors = 0;
   int               checked = 0;

   function automatic int unsigned effective_size(input logic [CFG_W-1:0] size,
                                                  input int unsigned limit);
      if (size == '0)
         return 1;
      if (int'(size) > limit)
         return limit;
      return 32'(size);
   endfunction

   task automatic restart_frame();
      column         = 0;
      row            = 0;
      row_sum        = '0;
      row_square_sum = '0;
   endtask

   task automatic predict_sums(input logic [PIXEL_W-1:0] pixel);
      int unsigned  w;
      int unsigned  h;
      int unsigned  c;
      sum_word_type word;
      w = effective_size(frame_width, MAX_WIDTH);
      h = effective_size(frame_height, MAX_HEIGHT);
      c = column;
      if (c >= w)
         c = 0;
      row_sum        = row_sum + SUM_W'(pixel);
      row_square_sum = row_square_sum + SQ_W'(pixel) * SQ_W'(pixel);
      word.area   = row_sum;
      word.square = row_square_sum;
      if (row != 0) begin
         word.area   = word.area + line_sum[COL_W'(c)];
         word.square = word.square + line_square_sum[COL_W'(c)];
      end
      line_sum[COL_W'(c)]        = word.area;
      line_square_sum[COL_W'(c)] = word.square;
      word.last = (c == w - 1) && (row >= h - 1);
      expected_sums.push_back(word);
      c++;
      if (c >= w) begin
         c              = 0;
         row_sum        = '0;
         row_square_sum = '0;
         row++;
         if (row >= h)
            row = 0;
      end
      column = c;
   endtask

   task automatic report(input string field, input logic [SQ_W-1:0] wanted,
                         input logic [SQ_W-1:0] got);
      errors++;
      if (errors <= 40)
         $display("%0t ns: %s expected %0d, got %0d", $time, field, wanted, got);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_width  = FRAME_WIDTH_RESET;
         frame_height = FRAME_HEIGHT_RESET;
         restart_frame();
         expected_sums.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_FRAME_WIDTH: begin
                  frame_width = csr_write_data;
                  restart_frame();
               end
               REG_FRAME_HEIGHT: begin
                  frame_height = csr_write_data;
                  restart_frame();
               end
               default: ;
            endcase
         end
         if (req_watch.valid && req_watch.ready)
            predict_sums(req_watch.pixel);
         if (rsp_watch.valid && rsp_watch.ready) begin
            if (expected_sums.size() == 0) begin
               errors++;
               if (errors <= 40)
                  $display("%0t ns: sum word expected none, got area_sum %0d", $time,
                           rsp_watch.area_sum);
            end else begin
               want = expected_sums.pop_front();
               checked++;
               if (rsp_watch.area_sum !== want.area)
                  report("area_sum", SQ_W'(want.area), SQ_W'(rsp_watch.area_sum));
               if (rsp_watch.square_area_sum !== want.square)
                  report("square_area_sum", want.square, rsp_watch.square_area_sum);
               if (rsp_watch.frame_last !== want.last)
                  report("frame_last", SQ_W'(want.last), SQ_W'(rsp_watch.frame_last));
            end
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_sums.size();
      checked_count  <= checked;
   end

endmodule

@@ verif/tb_integral_and_square_integral_image_top.sv @@
`timescale 1ns / 1ps
// Testbench top: reset, frame size writes, pixel stimulus with stalls, and the verdict.
module tb_integral_and_square_integral_image_top;
   import iisq_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PIXEL_BUDGET = 1450;

   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LOW  = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HIGH = CSR_INDEX_W'(3);

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_write_data;

   iisq_req_if req_chan ();
   iisq_rsp_if rsp_chan ();

   int mismatch_count;
   int pending_sums;
   int checked_sums;
   int cycle_count = 0;
   int pixels_sent = 0;
   int csr_writes = 0;
   bit steady = 1'b0;
   bit long_hold_request = 1'b0;

   integral_and_square_integral_image_top uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   integral_sum_checker sum_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_watch        (req_chan),
      .rsp_watch        (rsp_chan),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_sums),
      .checked_count    (checked_sums)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (60) @(posedge clock);
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 11) - 1) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(0, 15)) @(posedge clock);
         end
      end
   end

   function automatic int unsigned next_pixel();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   task automatic push_pixel(input int unsigned value);
      if (!steady && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.pixel <= PIXEL_W'(value);
      do @(posedge clock); while (!req_chan.ready);
      pixels_sent++;
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input int unsigned value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= CFG_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      csr_writes++;
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_sums != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int phase;
      int count;
      int mode;
      int unsigned width_value;
      int unsigned height_value;
      int unsigned cur_width;
      int unsigned cur_height;
      int random_pixels;

      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= REG_FRAME_WIDTH;
      csr_write_data   <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.pixel   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 3x2 frame, then wrap into a second frame
      write_register(REG_FRAME_WIDTH, 3);
      write_register(REG_FRAME_HEIGHT, 2);
      push_pixel(255);
      push_pixel(0);
      push_pixel(255);
      push_pixel(255);
      push_pixel(255);
      push_pixel(128);
      push_pixel(1);
      push_pixel(254);
      push_pixel(85);
      settle();

      // unused indexes leave the frame running
      write_register(REG_SPARE_LOW, 2047);
      write_register(REG_SPARE_HIGH, 0);
      push_pixel(170);
      push_pixel(15);
      push_pixel(240);
      settle();

      write_register(REG_FRAME_WIDTH, 0);
      write_register(REG_FRAME_HEIGHT, 0);
      push_pixel(255);
      push_pixel(255);
      push_pixel(0);
      settle();

      write_register(REG_FRAME_WIDTH, 1);
      write_register(REG_FRAME_HEIGHT, 3);
      push_pixel(200);
      push_pixel(255);
      push_pixel(255);
      push_pixel(7);
      settle();

      write_register(REG_FRAME_WIDTH, MAX_WIDTH);
      write_register(REG_FRAME_HEIGHT, MAX_HEIGHT);
      push_pixel(255);
      push_pixel(0);
      settle();
      write_register(REG_FRAME_HEIGHT, 2047);
      push_pixel(255);
      push_pixel(255);
      settle();
      write_register(REG_FRAME_HEIGHT, 2);
      push_pixel(1);
      push_pixel(255);

      cur_width     = MAX_WIDTH;
      cur_height    = 2;
      phase         = 0;
      random_pixels = 0;
      while (random_pixels < PIXEL_BUDGET) begin
         settle();
         if (random_pixels >= PIXEL_BUDGET - 200)
            steady = 1'b1;
         if (phase == 3) begin
            // one full row at the widest size, with the output held off
            write_register(REG_FRAME_WIDTH, $urandom_range(MAX_WIDTH + 1, 2047));
            write_register(REG_FRAME_HEIGHT, 2);
            cur_width  = MAX_WIDTH;
            cur_height = 2;
            count      = MAX_WIDTH + $urandom_range(4, 24);
            long_hold_request = 1'b1;
         end else begin
            case ($urandom_range(0, 9))
               0:       width_value = 0;
               7, 8:    width_value = $urandom_range(13, 64);
               9:       width_value = $urandom_range(1, 4);
               default: width_value = $urandom_range(1, 12);
            endcase
            height_value = $urandom_range(0, 8);
            mode = (phase == 4) ? 0 : $urandom_range(0, 4);
            if (mode <= 2) begin
               write_register(REG_FRAME_WIDTH, width_value);
               cur_width = (width_value == 0) ? 1 : width_value;
            end
            if (mode != 2 && mode != 4) begin
               write_register(REG_FRAME_HEIGHT, height_value);
               cur_height = (height_value == 0) ? 1 : height_value;
            end
            if ($urandom_range(0, 5) == 0)
               write_register($urandom_range(0, 1) ? REG_SPARE_LOW : REG_SPARE_HIGH,
                              $urandom_range(0, 2047));
            count = $urandom_range(1, 3 * cur_width * cur_height + 5);
            if (count > 120)
               count = 120;
         end
         repeat (count) push_pixel(next_pixel());
         random_pixels += count;
         phase++;
      end
      settle();

      $display("Sent %0d pixel words across %0d register writes, frame widths 1 to 1024,",
               pixels_sent, csr_writes);
      $display("with stalls on both channels; %0d sum words checked.", checked_sums);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/iisq_pkg.sv
hdl/iisq_channels.sv
hdl/integral_and_square_integral_image_top.sv
verif/integral_sum_checker.sv
verif/tb_integral_and_square_integral_image_top.sv
